### rtl/halfblock_sprite_cell_renderer_assert.svh
// ----------------------------------------------------------------------------
// Half-block renderer assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef HALFBLOCK_SPRITE_CELL_RENDERER_ASSERT_SVH
`define HALFBLOCK_SPRITE_CELL_RENDERER_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define HBSR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked during reset.
`define HBSR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also covers the reset cycles.
`define HBSR_ASSERT_ALWAYS_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/hbsr_pkg.sv
// ----------------------------------------------------------------------------
// hbsr_pkg
// Types, constants and byte tables for the half-block sprite cell renderer.
// ----------------------------------------------------------------------------
package hbsr_pkg;

    // cells rendered per input item, clamped to what fits in one byte
    localparam int CELLS_PER_ITEM = 4;
    localparam int NCELLS = (CELLS_PER_ITEM < 1) ? 1 :
                            ((CELLS_PER_ITEM > 4) ? 4 : CELLS_PER_ITEM);
    localparam logic [1:0] LAST_CELL = 2'(NCELLS - 1);

    // command queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // color modes
    typedef logic [1:0] t_mode;
    localparam t_mode MODE_BG_ON_BLACK  = 2'd0;
    localparam t_mode MODE_SPR_ON_BLACK = 2'd1;
    localparam t_mode MODE_SPR_ON_BG    = 2'd2;

    // escape sequence bytes
    localparam logic [7:0] ESC_BYTE   = 8'h1B;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_M       = 8'h6D;
    localparam logic [7:0] CH_ONE     = 8'h31;
    localparam logic [7:0] CH_TWO     = 8'h32;
    localparam logic [7:0] CH_THREE   = 8'h33;
    localparam logic [7:0] CH_FOUR    = 8'h34;
    localparam logic [7:0] DIGIT_BASE = 8'd48;

    // sequence byte positions of the final 'm'
    localparam logic [3:0] SEQ_END_BRIGHT = 4'd9;
    localparam logic [3:0] SEQ_END_NORMAL = 4'd10;

    // configuration registers
    typedef enum logic [2:0] {
        CFG_BG_COLOR    = 3'd0,
        CFG_GLYPH_EMPTY = 3'd1,
        CFG_GLYPH_UPPER = 3'd2,
        CFG_GLYPH_LOWER = 3'd3,
        CFG_GLYPH_WHOLE = 3'd4
    } t_cfg_idx;

    localparam logic [3:0] RST_BG_COLOR    = 4'd2;
    localparam logic [7:0] RST_GLYPH_EMPTY = 8'd32;
    localparam logic [7:0] RST_GLYPH_UPPER = 8'd223;
    localparam logic [7:0] RST_GLYPH_LOWER = 8'd220;
    localparam logic [7:0] RST_GLYPH_WHOLE = 8'd219;

    typedef struct packed {
        logic [3:0] bg_color;
        logic [7:0] glyph_empty;
        logic [7:0] glyph_upper;
        logic [7:0] glyph_lower;
        logic [7:0] glyph_whole;
    } t_cfg;

    // one command: a color sequence or a single glyph byte
    typedef struct packed {
        logic       is_seq;
        logic [3:0] fg;
        logic [3:0] bg;
        logic [7:0] glyph;
        logic       last;
    } t_cmd;

    typedef enum logic [1:0] {
        F_IDLE,
        F_START,
        F_CELL
    } t_fstate;

    typedef enum logic {
        B_FETCH,
        B_SEQ
    } t_bstate;

    function automatic logic [3:0] seq_end(input logic [3:0] fg);
        return fg[3] ? SEQ_END_BRIGHT : SEQ_END_NORMAL;
    endfunction

    // Byte at position pos of the color sequence for fg on bg.
    // Normal intensity has "22" where bright has "1"; past that point the
    // normal sequence is the bright one shifted by one.
    function automatic logic [7:0] seq_byte(input logic [3:0] fg, input logic [3:0] bg,
                                            input logic [3:0] pos);
        logic [3:0] p;
        logic [7:0] b;
        p = (!fg[3] && pos >= 4'd4) ? pos - 4'd1 : pos;
        case (p)
            4'd0:    b = ESC_BYTE;
            4'd1:    b = CH_LBRACK;
            4'd2:    b = CH_ONE;
            4'd3:    b = CH_SEMI;
            4'd4:    b = CH_THREE;
            4'd5:    b = DIGIT_BASE + {5'd0, fg[2:0]};
            4'd6:    b = CH_SEMI;
            4'd7:    b = CH_FOUR;
            4'd8:    b = DIGIT_BASE + {4'd0, bg};
            default: b = CH_M;
        endcase
        if (!fg[3] && (pos == 4'd2 || pos == 4'd3)) begin
            b = CH_TWO;
        end
        return b;
    endfunction

endpackage

### rtl/hbsr_front.sv
// ----------------------------------------------------------------------------
// hbsr_front
// Accepts items, tracks the color mode and issues one command per cycle while the queue has room.
// ----------------------------------------------------------------------------
module hbsr_front import hbsr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_sprite_cells,
    input  logic [7:0] i_backdrop_cells,
    input  logic [3:0] i_sprite_color,
    input  logic       i_start_sprite,
    input  t_cfg       i_cfg,
    input  logic       i_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    t_fstate    r_state, n_state;
    t_mode      r_mode, n_mode;
    logic [1:0] r_cell, n_cell;
    logic [7:0] r_spr;
    logic [7:0] r_bd;
    logic [3:0] r_col;

    logic [1:0] cell_s;
    logic [1:0] cell_b;
    t_mode      need;
    logic [7:0] glyph;
    logic [3:0] seq_fg;
    logic [3:0] seq_bg;
    logic       cell_last;
    logic       glyph_done;
    logic       accept;

    // classify the current cell
    always_comb begin
        cell_s = r_spr[{r_cell, 1'b0} +: 2];
        cell_b = r_bd[{r_cell, 1'b0} +: 2];
        case (cell_s)
            2'd0: begin
                need = MODE_BG_ON_BLACK;
                case (cell_b)
                    2'd0:    glyph = i_cfg.glyph_empty;
                    2'd1:    glyph = i_cfg.glyph_upper;
                    2'd2:    glyph = i_cfg.glyph_lower;
                    default: glyph = i_cfg.glyph_whole;
                endcase
            end
            2'd1: begin
                need  = cell_b[1] ? MODE_SPR_ON_BG : MODE_SPR_ON_BLACK;
                glyph = i_cfg.glyph_upper;
            end
            2'd2: begin
                need  = cell_b[0] ? MODE_SPR_ON_BG : MODE_SPR_ON_BLACK;
                glyph = i_cfg.glyph_lower;
            end
            default: begin
                need  = MODE_SPR_ON_BLACK;
                glyph = i_cfg.glyph_whole;
            end
        endcase
        case (need)
            MODE_BG_ON_BLACK: begin
                seq_fg = i_cfg.bg_color;
                seq_bg = 4'd0;
            end
            MODE_SPR_ON_BLACK: begin
                seq_fg = r_col;
                seq_bg = 4'd0;
            end
            default: begin
                seq_fg = r_col;
                seq_bg = i_cfg.bg_color;
            end
        endcase
        cell_last  = (r_cell == LAST_CELL);
        glyph_done = (r_state == F_CELL) && !i_full && (need == r_mode) && cell_last;
        o_ready    = (r_state == F_IDLE) || glyph_done;
        accept     = i_valid && o_ready;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: begin
                if (accept) begin
                    n_state = i_start_sprite ? F_START : F_CELL;
                end
            end
            F_START: begin
                if (!i_full) begin
                    n_state = F_CELL;
                end
            end
            F_CELL: begin
                if (glyph_done) begin
                    n_state = accept ? (i_start_sprite ? F_START : F_CELL) : F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    // outputs and datapath updates
    always_comb begin
        o_push = 1'b0;
        o_cmd  = '0;
        n_mode = r_mode;
        n_cell = r_cell;
        case (r_state)
            F_START: begin
                o_push     = !i_full;
                o_cmd.is_seq = 1'b1;
                o_cmd.fg   = i_cfg.bg_color;
                o_cmd.bg   = 4'd0;
                if (!i_full) begin
                    n_mode = MODE_BG_ON_BLACK;
                end
            end
            F_CELL: begin
                o_push = !i_full;
                if (need != r_mode) begin
                    o_cmd.is_seq = 1'b1;
                    o_cmd.fg     = seq_fg;
                    o_cmd.bg     = seq_bg;
                    if (!i_full) begin
                        n_mode = need;
                    end
                end else begin
                    o_cmd.glyph = glyph;
                    o_cmd.last  = cell_last;
                    if (!i_full && !cell_last) begin
                        n_cell = r_cell + 2'd1;
                    end
                end
            end
            default: ;
        endcase
        if (accept) begin
            n_cell = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_mode  <= MODE_BG_ON_BLACK;
            r_cell  <= 2'd0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_cell  <= n_cell;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_spr <= i_sprite_cells;
            r_bd  <= i_backdrop_cells;
            r_col <= i_sprite_color;
        end
    end

endmodule

### rtl/hbsr_fifo.sv
// ----------------------------------------------------------------------------
// hbsr_fifo
// Small command queue between the front and back parts.
// ----------------------------------------------------------------------------
module hbsr_fifo import hbsr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_head,
    output logic o_full,
    output logic o_empty
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, n_wr;
    logic [QPTR_W-1:0] r_rd, n_rd;
    logic [QPTR_W:0]   r_cnt, n_cnt;

    always_comb begin
        o_full  = (r_cnt == (QPTR_W+1)'(QDEPTH));
        o_empty = (r_cnt == '0);
        o_head  = r_mem[r_rd];
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_cnt   = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

### rtl/hbsr_back.sv
// ----------------------------------------------------------------------------
// hbsr_back
// Expands commands into terminal bytes, one byte per cycle while the output
// is not stalled, into the output register.
// ----------------------------------------------------------------------------
module hbsr_back import hbsr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_cmd       i_cmd,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_byte,
    output logic       o_last
);

    t_bstate    r_state, n_state;
    logic [3:0] r_pos, n_pos;
    logic [3:0] r_fg;
    logic [3:0] r_bg;
    logic       r_valid;
    logic [7:0] r_byte, n_byte;
    logic       r_last, n_last;
    logic       slot_free;
    logic       load;

    assign slot_free = !r_valid || i_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_FETCH: begin
                if (slot_free && !i_empty && i_cmd.is_seq) begin
                    n_state = B_SEQ;
                end
            end
            B_SEQ: begin
                if (slot_free && r_pos == seq_end(r_fg)) begin
                    n_state = B_FETCH;
                end
            end
            default: n_state = B_FETCH;
        endcase
    end

    // outputs
    always_comb begin
        o_pop  = 1'b0;
        load   = 1'b0;
        n_byte = r_byte;
        n_last = r_last;
        n_pos  = r_pos;
        case (r_state)
            B_FETCH: begin
                o_pop = slot_free && !i_empty;
                load  = o_pop;
                if (i_cmd.is_seq) begin
                    n_byte = ESC_BYTE;
                    n_last = 1'b0;
                    n_pos  = 4'd1;
                end else begin
                    n_byte = i_cmd.glyph;
                    n_last = i_cmd.last;
                end
            end
            B_SEQ: begin
                load   = slot_free;
                n_byte = seq_byte(r_fg, r_bg, r_pos);
                n_last = 1'b0;
                n_pos  = r_pos + 4'd1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_FETCH;
            r_valid <= 1'b0;
            r_pos   <= 4'd0;
        end else begin
            r_state <= n_state;
            if (slot_free) begin
                r_valid <= load;
            end
            if (load) begin
                r_pos <= n_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= n_byte;
            r_last <= n_last;
        end
        if (o_pop) begin
            r_fg <= i_cmd.fg;
            r_bg <= i_cmd.bg;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_last  = r_last;

endmodule

### rtl/halfblock_sprite_cell_renderer.sv
// ----------------------------------------------------------------------------
// halfblock_sprite_cell_renderer
// Turns sprite and backdrop cell bytes into a terminal byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one transfer carries four 2-bit sprite cells, four 2-bit
//   backdrop cells, a 4-bit sprite color (tdata) and the start flag (tuser).
//   Master stream: one terminal byte per transfer; tlast marks the final
//   byte caused by an input item.
//   Config port: write background color and the four glyph codes while the
//   block is idle; a write lands on the clock edge with i_cfg_we high.
//   Throughput: one output byte per cycle while the output port accepts.
//   An item produces 4 to 59 bytes. The front issues one command per cycle
//   (a color change or a glyph) while the queue has room, and the next item
//   is taken as the last glyph command leaves.
//   Reset: synchronous, active low; color mode returns to backdrop on black,
//   registers take their defaults, the queue empties, no bytes are pending.
//   Stall: a held output byte stays stable; the command queue fills behind
//   it and then the front stops taking items.
// ----------------------------------------------------------------------------
module halfblock_sprite_cell_renderer import hbsr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] sprite_cells, [15:8] backdrop_cells, [19:16] sprite_color, [23:20] zero
    input  logic [23:0] s_axis_tdata,
    // [0] start_sprite
    input  logic        s_axis_tuser,
    // master stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] out_byte
    output logic [7:0]  m_axis_tdata,
    output logic        m_axis_tlast,
    // config write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data
);

    t_cfg r_cfg;
    t_cmd push_cmd;
    t_cmd head_cmd;
    logic push;
    logic pop;
    logic full;
    logic empty;

    // configuration registers; indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bg_color    <= RST_BG_COLOR;
            r_cfg.glyph_empty <= RST_GLYPH_EMPTY;
            r_cfg.glyph_upper <= RST_GLYPH_UPPER;
            r_cfg.glyph_lower <= RST_GLYPH_LOWER;
            r_cfg.glyph_whole <= RST_GLYPH_WHOLE;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_BG_COLOR:    r_cfg.bg_color    <= i_cfg_data[3:0];
                CFG_GLYPH_EMPTY: r_cfg.glyph_empty <= i_cfg_data;
                CFG_GLYPH_UPPER: r_cfg.glyph_upper <= i_cfg_data;
                CFG_GLYPH_LOWER: r_cfg.glyph_lower <= i_cfg_data;
                CFG_GLYPH_WHOLE: r_cfg.glyph_whole <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // front: decides color changes and glyphs per cell
    hbsr_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (s_axis_tvalid),
        .o_ready          (s_axis_tready),
        .i_sprite_cells   (s_axis_tdata[7:0]),
        .i_backdrop_cells (s_axis_tdata[15:8]),
        .i_sprite_color   (s_axis_tdata[19:16]),
        .i_start_sprite   (s_axis_tuser),
        .i_cfg            (r_cfg),
        .i_full           (full),
        .o_push           (push),
        .o_cmd            (push_cmd)
    );

    // command queue decouples classification from byte output
    hbsr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head_cmd),
        .o_full  (full),
        .o_empty (empty)
    );

    // back: escape sequence expansion and output register
    hbsr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_cmd   (head_cmd),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_byte  (m_axis_tdata),
        .o_last  (m_axis_tlast)
    );

endmodule

### rtl/hbsr_checker.sv
// ----------------------------------------------------------------------------
// hbsr_checker
// Port-level checks for the half-block renderer, bound to the top level.
// ----------------------------------------------------------------------------
`include "halfblock_sprite_cell_renderer_assert.svh"

module hbsr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tlast
);

    logic [3:0] r_pending;
    logic       in_xfer;
    logic       out_end;

    assign in_xfer = s_axis_tvalid && s_axis_tready;
    assign out_end = m_axis_tvalid && m_axis_tready && m_axis_tlast;

    // items taken whose final byte has not yet gone out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 4'd0;
        end else begin
            r_pending <= r_pending + {3'd0, in_xfer} - {3'd0, out_end};
        end
    end

    `HBSR_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output changed while stalled")
    `HBSR_ASSERT_SAME(a_no_orphan_byte, m_axis_tvalid && m_axis_tready, r_pending != 4'd0, "byte sent with no item pending")
    `HBSR_ASSERT_SAME(a_idle_ready, r_pending == 4'd0, s_axis_tready, "idle block not ready for input")
    `HBSR_ASSERT_ALWAYS_NEXT(a_reset_quiet, !i_rst_n, !m_axis_tvalid, "output valid right after reset")

endmodule

bind halfblock_sprite_cell_renderer hbsr_checker u_hbsr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: half-block sprite cell renderer testbench
// Streams sprite/backdrop cell words into the renderer and checks every
// terminal byte against an in-bench predictor. The predictor tracks the color
// mode and the register values. Input and output sides both stall at random.
// Register settings change between phases, with all-zero and all-ones among
// them.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import hbsr_pkg::*;

    // cells per word, clamped to what a byte holds
    localparam int CELL_COUNT = (CELLS_PER_ITEM < 1) ? 1 :
                                ((CELLS_PER_ITEM > 4) ? 4 : CELLS_PER_ITEM);

    // 2-bit cell codes: bit0 top half, bit1 bottom half
    localparam logic [1:0] CELL_NONE   = 2'd0;
    localparam logic [1:0] CELL_TOP    = 2'd1;
    localparam logic [1:0] CELL_BOTTOM = 2'd2;

    // first index past the register file; writes there must change nothing
    localparam logic [2:0] CFG_IDX_SPARE = 3'd5;

    localparam int WORDS_PER_PHASE = 50;
    localparam int PHASE_COUNT     = 9;

    typedef struct packed {
        logic [7:0] sprite;
        logic [7:0] backdrop;
        logic [3:0] color;
        logic       start;
    } t_cell_word;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_term_byte;

    // DUT ports, all inputs known from time zero
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [7:0]  i_cfg_data = '0;

    // predictor copy of registers and color mode
    logic [3:0] bg_color_m    = RST_BG_COLOR;
    logic [7:0] glyph_empty_m = RST_GLYPH_EMPTY;
    logic [7:0] glyph_upper_m = RST_GLYPH_UPPER;
    logic [7:0] glyph_lower_m = RST_GLYPH_LOWER;
    logic [7:0] glyph_whole_m = RST_GLYPH_WHOLE;
    t_mode      color_mode_m  = MODE_BG_ON_BLACK;

    t_cell_word words_to_send[$];
    t_term_byte expected_term_bytes[$];
    logic [7:0] word_bytes[$];      // bytes of the word being predicted
    int         mismatch_count = 0;
    bit         steady = 1'b0;      // no idling on either side while set

    halfblock_sprite_cell_renderer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    // ESC [ 1 ; 3 f ; 4 g m  when bright, ESC [ 2 2 ; 3 f ; 4 g m otherwise
    task automatic emit_color_seq(input logic [3:0] fg, input logic [3:0] bg);
        word_bytes.push_back(ESC_BYTE);
        word_bytes.push_back(CH_LBRACK);
        if (fg[3]) begin
            word_bytes.push_back(CH_ONE);
        end else begin
            word_bytes.push_back(CH_TWO);
            word_bytes.push_back(CH_TWO);
        end
        word_bytes.push_back(CH_SEMI);
        word_bytes.push_back(CH_THREE);
        word_bytes.push_back(DIGIT_BASE + {5'd0, fg[2:0]});
        word_bytes.push_back(CH_SEMI);
        word_bytes.push_back(CH_FOUR);
        word_bytes.push_back(DIGIT_BASE + {4'd0, bg});  // 10..15 land past '9'
        word_bytes.push_back(CH_M);
    endtask

    // switch color mode, emitting its sequence only on a change
    task automatic enter_mode(input t_mode want, input logic [3:0] scolor);
        if (want != color_mode_m) begin
            case (want)
                MODE_BG_ON_BLACK:  emit_color_seq(bg_color_m, 4'd0);
                MODE_SPR_ON_BLACK: emit_color_seq(scolor, 4'd0);
                default:           emit_color_seq(scolor, bg_color_m);
            endcase
            color_mode_m = want;
        end
    endtask

    // expected byte stream of one accepted word, appended to the scoreboard
    task automatic render_cells(input t_cell_word w);
        logic [1:0] s;
        logic [1:0] b;
        word_bytes.delete();
        if (w.start) begin
            emit_color_seq(bg_color_m, 4'd0);
            color_mode_m = MODE_BG_ON_BLACK;
        end
        for (int i = 0; i < CELL_COUNT; i++) begin
            s = w.sprite[2*i +: 2];
            b = w.backdrop[2*i +: 2];
            case (s)
                CELL_NONE: begin
                    enter_mode(MODE_BG_ON_BLACK, w.color);
                    case (b)
                        CELL_NONE:   word_bytes.push_back(glyph_empty_m);
                        CELL_TOP:    word_bytes.push_back(glyph_upper_m);
                        CELL_BOTTOM: word_bytes.push_back(glyph_lower_m);
                        default:     word_bytes.push_back(glyph_whole_m);
                    endcase
                end
                CELL_TOP: begin
                    // lower half shows backdrop when its bottom is lit
                    enter_mode(b[1] ? MODE_SPR_ON_BG : MODE_SPR_ON_BLACK, w.color);
                    word_bytes.push_back(glyph_upper_m);
                end
                CELL_BOTTOM: begin
                    enter_mode(b[0] ? MODE_SPR_ON_BG : MODE_SPR_ON_BLACK, w.color);
                    word_bytes.push_back(glyph_lower_m);
                end
                default: begin
                    enter_mode(MODE_SPR_ON_BLACK, w.color);
                    word_bytes.push_back(glyph_whole_m);
                end
            endcase
        end
        foreach (word_bytes[k]) begin
            expected_term_bytes.push_back('{data: word_bytes[k],
                                            last: (k == word_bytes.size() - 1)});
        end
    endtask

    // ------------------------------------------------------------------- driver

    // next word goes out once the current one transfers; ~30% idle cycles
    always @(posedge i_clk) begin
        t_cell_word w;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (words_to_send.size() != 0 && (steady || $urandom_range(99) >= 30)) begin
                w = words_to_send.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {4'd0, w.color, w.backdrop, w.sprite};
                s_axis_tuser  <= w.start;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------ monitor

    // output check first, then prediction of any word accepted on this edge
    always @(posedge i_clk) begin
        t_term_byte want;
        t_cell_word got_word;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= steady || ($urandom_range(99) >= 30);
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_term_bytes.size() == 0) begin
                    $display("%0t: unexpected byte: expected none, actual %02h last %0b",
                             $time, m_axis_tdata, m_axis_tlast);
                    mismatch_count++;
                end else begin
                    want = expected_term_bytes.pop_front();
                    if (m_axis_tdata !== want.data) begin
                        $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                                 $time, want.data, m_axis_tdata);
                        mismatch_count++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $display("%0t: last_byte mismatch: expected %0b, actual %0b",
                                 $time, want.last, m_axis_tlast);
                        mismatch_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                got_word.sprite   = s_axis_tdata[7:0];
                got_word.backdrop = s_axis_tdata[15:8];
                got_word.color    = s_axis_tdata[19:16];
                got_word.start    = s_axis_tuser;
                render_cells(got_word);
            end
        end
    end

    // ----------------------------------------------------------------- sequence

    // wait until every queued word has transferred and every byte came back
    task automatic drain();
        while (words_to_send.size() != 0 || s_axis_tvalid || expected_term_bytes.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // one register write; lands on the next edge, predictor follows at once
    task automatic write_reg(input logic [2:0] idx, input logic [7:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        case (idx)
            CFG_BG_COLOR:    bg_color_m    = value[3:0];
            CFG_GLYPH_EMPTY: glyph_empty_m = value;
            CFG_GLYPH_UPPER: glyph_upper_m = value;
            CFG_GLYPH_LOWER: glyph_lower_m = value;
            CFG_GLYPH_WHOLE: glyph_whole_m = value;
            default: ;      // past the register file: ignored
        endcase
    endtask

    function automatic t_cell_word random_word();
        t_cell_word w;
        w.sprite   = 8'($urandom_range(255));
        w.backdrop = 8'($urandom_range(255));
        w.color    = 4'($urandom_range(15));
        w.start    = ($urandom_range(7) == 0);
        return w;
    endfunction

    initial begin
        logic [7:0] fill;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed words at reset register values
        words_to_send.push_back(t_cell_word'{8'h00, 8'h00, 4'd0,  1'b1});
        words_to_send.push_back(t_cell_word'{8'h00, 8'hE4, 4'd0,  1'b0}); // every backdrop glyph
        words_to_send.push_back(t_cell_word'{8'h00, 8'h00, 4'd0,  1'b0}); // no mode change
        words_to_send.push_back(t_cell_word'{8'hFF, 8'h00, 4'd0,  1'b0});
        words_to_send.push_back(t_cell_word'{8'hFF, 8'hFF, 4'd15, 1'b0});
        words_to_send.push_back(t_cell_word'{8'h55, 8'h00, 4'd7,  1'b0}); // top on black
        words_to_send.push_back(t_cell_word'{8'h55, 8'hAA, 4'd8,  1'b0}); // top on backdrop
        words_to_send.push_back(t_cell_word'{8'hAA, 8'h00, 4'd3,  1'b0}); // bottom on black
        words_to_send.push_back(t_cell_word'{8'hAA, 8'h55, 4'd12, 1'b0}); // bottom on backdrop
        words_to_send.push_back(t_cell_word'{8'hD3, 8'h20, 4'd5,  1'b1}); // longest byte run
        words_to_send.push_back(t_cell_word'{8'hD3, 8'h20, 4'd9,  1'b1});
        words_to_send.push_back(t_cell_word'{8'hFF, 8'hFF, 4'd0,  1'b1});
        words_to_send.push_back(t_cell_word'{8'h1B, 8'h72, 4'd15, 1'b1});
        words_to_send.push_back(t_cell_word'{8'hE4, 8'h1B, 4'd6,  1'b0});
        words_to_send.push_back(t_cell_word'{8'h00, 8'hFF, 4'd8,  1'b1});
        words_to_send.push_back(t_cell_word'{8'h39, 8'hC6, 4'd10, 1'b0});

        // phase 0 all zeros, phase 1 all ones (bright backdrop), then random
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            drain();
            steady <= (phase == 4);
            fill = (phase == 1) ? 8'hFF : 8'h00;
            write_reg(CFG_BG_COLOR,    (phase < 2) ? fill : 8'($urandom_range(255)));
            write_reg(CFG_GLYPH_EMPTY, (phase < 2) ? fill : 8'($urandom_range(255)));
            write_reg(CFG_GLYPH_UPPER, (phase < 2) ? fill : 8'($urandom_range(255)));
            write_reg(CFG_GLYPH_LOWER, (phase < 2) ? fill : 8'($urandom_range(255)));
            write_reg(CFG_GLYPH_WHOLE, (phase < 2) ? fill : 8'($urandom_range(255)));
            write_reg(CFG_IDX_SPARE + 3'($urandom_range(2)), 8'($urandom_range(255)));
            @(posedge i_clk);
            i_cfg_we <= 1'b0;
            // fresh phase restarts from a known mode
            words_to_send.push_back(t_cell_word'{8'hD3, 8'h20, 4'($urandom_range(15)), 1'b1});
            for (int n = 0; n < WORDS_PER_PHASE; n++)
                words_to_send.push_back(random_word());
        end

        drain();
        repeat (16) @(posedge i_clk);
        if (mismatch_count == 0 && expected_term_bytes.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // watchdog: far past the slowest correct run
    initial begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
